@@ hdl/contrast_sepia_pixel_macros.svh @@
// Assertion macros shared by the contrast sepia pixel modules.
`ifndef CONTRAST_SEPIA_PIXEL_MACROS_SVH
`define CONTRAST_SEPIA_PIXEL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/csp_pkg.sv @@
// Types, widths and sepia coefficients for the contrast sepia pixel block.
package csp_pkg;

  localparam int COMPONENT_BITS = 8;
  localparam int NCH            = 3;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC      = 14;
  localparam int COEF_W         = 10;
  localparam int SUM_FRAC       = GAIN_FRAC + 10;
  localparam int PROD_W         = COMPONENT_BITS + GAIN_W;
  localparam int CVAL_W         = COMPONENT_BITS + GAIN_FRAC;
  localparam int MAC_W          = CVAL_W + COEF_W;
  localparam int SUM_W          = MAC_W + 2;

  typedef logic [COMPONENT_BITS-1:0] comp_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic [COEF_W-1:0]         coef_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic [CVAL_W-1:0]         cval_t;
  typedef logic [MAC_W-1:0]          mac_t;
  typedef logic [SUM_W-1:0]          sum_t;

  typedef comp_t [NCH-1:0]           pix_t;
  typedef prod_t [NCH-1:0]           prod_vec_t;
  typedef mac_t  [NCH-1:0][NCH-1:0]  mac_mat_t;

  localparam gain_t GAIN_RESET = gain_t'(18063);

  // Saturation points: full scale in Q.14 and in Q.24.
  localparam cval_t CVAL_MAX = cval_t'(((64'd1 << COMPONENT_BITS) - 64'd1) << GAIN_FRAC);
  localparam sum_t  SUM_TOP  = sum_t'(((64'd1 << COMPONENT_BITS) - 64'd1) << SUM_FRAC);
  localparam sum_t  ROUND_HALF = sum_t'(64'd1 << (SUM_FRAC - 1));

  // Sepia matrix in Q0.10, [out row][in channel], channel 0 is red.
  localparam coef_t SEPIA_COEF [NCH][NCH] = '{
    '{coef_t'(402), coef_t'(787), coef_t'(194)},
    '{coef_t'(357), coef_t'(702), coef_t'(172)},
    '{coef_t'(279), coef_t'(547), coef_t'(134)}
  };

endpackage

@@ hdl/contrast_sepia_pixel.sv @@
// Three register stages (gain, matrix, round); a request accepted into the gain register
// passes through the matrix and round registers before pix_valid_o rises.
// Throughput: one pixel per cycle unless stalled; each multiplier or adder row is used once.
// A stalled output holds its stage; earlier empty stages still take requests.
// Reset clears all stage valid bits and loads the contrast gain with 18063 (1.05^2, Q2.14).
// Top level of the contrast sepia pixel block.
module contrast_sepia_pixel (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [csp_pkg::GAIN_W-1:0]          cfg_data_i,
  input  logic                                pix_valid_i,
  output logic                                pix_stall_o,
  input  logic [csp_pkg::COMPONENT_BITS-1:0]  red_in_i,
  input  logic [csp_pkg::COMPONENT_BITS-1:0]  green_in_i,
  input  logic [csp_pkg::COMPONENT_BITS-1:0]  blue_in_i,
  output logic                                pix_valid_o,
  input  logic                                pix_stall_i,
  output logic [csp_pkg::COMPONENT_BITS-1:0]  red_out_o,
  output logic [csp_pkg::COMPONENT_BITS-1:0]  green_out_o,
  output logic [csp_pkg::COMPONENT_BITS-1:0]  blue_out_o
);

  csp_pkg::gain_t     gain_q;
  csp_pkg::gain_t     gain_d;
  csp_pkg::pix_t      pix_in;
  csp_pkg::pix_t      pix_out;
  csp_pkg::prod_vec_t prod;
  csp_pkg::mac_mat_t  mac;
  logic               g_ready;
  logic               g_valid;
  logic               m_ready;
  logic               m_valid;
  logic               r_ready;

  assign gain_d = cfg_we_i ? cfg_data_i : gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= csp_pkg::GAIN_RESET;
    end else begin
      gain_q <= gain_d;
    end
  end

  assign pix_in[0] = red_in_i;
  assign pix_in[1] = green_in_i;
  assign pix_in[2] = blue_in_i;

  csp_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_valid_i),
    .pix_i   (pix_in),
    .gain_i  (gain_q),
    .ready_o (g_ready),
    .valid_o (g_valid),
    .prod_o  (prod),
    .ready_i (m_ready)
  );

  csp_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid),
    .prod_i  (prod),
    .ready_o (m_ready),
    .valid_o (m_valid),
    .mac_o   (mac),
    .ready_i (r_ready)
  );

  csp_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .mac_i   (mac),
    .ready_o (r_ready),
    .valid_o (pix_valid_o),
    .pix_o   (pix_out),
    .ready_i (!pix_stall_i)
  );

  assign pix_stall_o = !g_ready;
  assign red_out_o   = pix_out[0];
  assign green_out_o = pix_out[1];
  assign blue_out_o  = pix_out[2];

`include "contrast_sepia_pixel_macros.svh"

  `CSP_ASSERT_NOW(a_top_no_stall_empty, !g_valid, !pix_stall_o, "top: stall with empty first stage")
  `CSP_ASSERT_NOW(a_top_flow, !pix_valid_o, !pix_stall_o, "top: stall with empty output stage")

endmodule

@@ hdl/csp_gain.sv @@
// Stage 1: multiply each component by the contrast gain.
module csp_gain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  csp_pkg::pix_t      pix_i,
  input  csp_pkg::gain_t     gain_i,
  output logic               ready_o,
  output logic               valid_o,
  output csp_pkg::prod_vec_t prod_o,
  input  logic               ready_i
);

  logic               v_q;
  logic               v_d;
  logic               load;
  csp_pkg::prod_vec_t prod_q;
  csp_pkg::prod_vec_t prod_d;

  assign ready_o = !v_q || ready_i;
  assign load    = valid_i && ready_o;
  assign v_d     = ready_o ? valid_i : v_q;

  always_comb begin
    for (int k = 0; k < csp_pkg::NCH; k++) begin
      prod_d[k] = csp_pkg::prod_t'(pix_i[k]) * csp_pkg::prod_t'(gain_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = v_q;
  assign prod_o  = prod_q;

`include "contrast_sepia_pixel_macros.svh"

  `CSP_ASSERT_NEXT(a_gain_load_valid, load, v_q, "csp_gain: accepted request did not register")

endmodule

@@ hdl/csp_matrix.sv @@
// Stage 2: clamp the contrast values and form the nine sepia products.
module csp_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  csp_pkg::prod_vec_t prod_i,
  output logic               ready_o,
  output logic               valid_o,
  output csp_pkg::mac_mat_t  mac_o,
  input  logic               ready_i
);

  logic              v_q;
  logic              v_d;
  logic              load;
  csp_pkg::cval_t    cval [csp_pkg::NCH];
  csp_pkg::mac_mat_t mac_q;
  csp_pkg::mac_mat_t mac_d;

  assign ready_o = !v_q || ready_i;
  assign load    = valid_i && ready_o;
  assign v_d     = ready_o ? valid_i : v_q;

  always_comb begin
    for (int k = 0; k < csp_pkg::NCH; k++) begin
      // gain above one saturates at full scale before the matrix
      if (prod_i[k] > csp_pkg::prod_t'(csp_pkg::CVAL_MAX)) begin
        cval[k] = csp_pkg::CVAL_MAX;
      end else begin
        cval[k] = csp_pkg::cval_t'(prod_i[k]);
      end
    end
    for (int r = 0; r < csp_pkg::NCH; r++) begin
      for (int c = 0; c < csp_pkg::NCH; c++) begin
        mac_d[r][c] = csp_pkg::mac_t'(cval[c]) * csp_pkg::mac_t'(csp_pkg::SEPIA_COEF[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mac_q <= mac_d;
    end
  end

  assign valid_o = v_q;
  assign mac_o   = mac_q;

`include "contrast_sepia_pixel_macros.svh"

  `CSP_ASSERT_NEXT(a_matrix_hold, v_q && !ready_i, v_q && $stable(mac_q), "csp_matrix: held request changed")

endmodule

@@ hdl/csp_round.sv @@
// Stage 3: sum each sepia row, clamp to full scale and round to nearest.
module csp_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  csp_pkg::mac_mat_t mac_i,
  output logic              ready_o,
  output logic              valid_o,
  output csp_pkg::pix_t     pix_o,
  input  logic              ready_i
);

  logic          v_q;
  logic          v_d;
  logic          load;
  csp_pkg::sum_t sum [csp_pkg::NCH];
  csp_pkg::sum_t rnd [csp_pkg::NCH];
  csp_pkg::pix_t pix_q;
  csp_pkg::pix_t pix_d;

  assign ready_o = !v_q || ready_i;
  assign load    = valid_i && ready_o;
  assign v_d     = ready_o ? valid_i : v_q;

  always_comb begin
    for (int r = 0; r < csp_pkg::NCH; r++) begin
      sum[r] = csp_pkg::sum_t'(mac_i[r][0]) + csp_pkg::sum_t'(mac_i[r][1])
             + csp_pkg::sum_t'(mac_i[r][2]);
      if (sum[r] > csp_pkg::SUM_TOP) begin
        sum[r] = csp_pkg::SUM_TOP;
      end
      // round half up; cannot pass full scale after the clamp
      rnd[r]   = sum[r] + csp_pkg::ROUND_HALF;
      pix_d[r] = rnd[r][csp_pkg::SUM_FRAC +: csp_pkg::COMPONENT_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = v_q;
  assign pix_o   = pix_q;

`include "contrast_sepia_pixel_macros.svh"

  `CSP_ASSERT_NOW(a_round_ready, !v_q, ready_o, "csp_round: empty output stage not ready")

endmodule
